// ----- sv/assert_macros.svh -----
// Assertion macros for the bound checker in uraa_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define URAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition never holds outside reset.
`define URAA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/uraa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package uraa_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 10;
  localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Field and datapath widths
  localparam int DIST_W     = 24;
  localparam int SUM_W      = DIST_W + CNT_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int TIMER_W    = 22;
  localparam int TRIG_W     = 8;
  localparam int WEIGHT_W   = 4;
  localparam int WMUL_W     = 14;
  localparam int PROD_W     = DIST_W + WMUL_W;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Scale factors: distance = width*281 >> 6, half period = avg*weight*625 >> 4
  localparam int DIST_SCALE  = 281;
  localparam int DIST_SHIFT  = 6;
  localparam int DIST_PROD_W = TIMER_W + 9;
  localparam int BEEP_SCALE  = 625;
  localparam int BEEP_SHIFT  = 4;

  // Measurement status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RISE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_WEIGHT    = 3'd5;

  // Configuration reset values
  localparam logic [TIMER_W-1:0]  RST_ECHO_TIMEOUT   = 22'd2000000;
  localparam logic [TRIG_W-1:0]   RST_TRIGGER_LENGTH = 8'd10;
  localparam logic [TIMER_W-1:0]  RST_CYCLE_GAP      = 22'd50000;
  localparam logic [DIST_W-1:0]   RST_NEAR_LIMIT     = 24'd512;
  localparam logic [DIST_W-1:0]   RST_FAR_LIMIT      = 24'd3840;
  localparam logic [WEIGHT_W-1:0] RST_BEEP_WEIGHT    = 4'd1;

  // Sequencer to averaging engine
  typedef struct packed {
    logic               start;
    logic [TIMER_W-1:0] width;
  } uraa_req_t;

  // Averaging engine to sequencer
  typedef struct packed {
    logic               done;
    logic [DIST_W-1:0]  average;
    logic [TIMER_W-1:0] half_period;
  } uraa_rsp_t;

endpackage
`default_nettype wire

// ----- sv/ultrasonic_range_average_alarm_core.sv -----
// Ultrasonic ranging sequencer with a ring average and proximity buzzer. Each input
// beat is one microsecond tick carrying the echo level, and each yields one output
// beat (trigger and buzzer drive, held average and status, and a flag on the tick
// that produced a new average). An ordinary tick is taken whenever the result side
// is free. The tick that ends a measurement waits on the averaging engine: the
// old slot is read and the distance written back into the ring memory, the running
// sum and nonzero count are updated, and a bit-serial divider spends one cycle per
// sum bit (SUM_W = 28) before the buzzer period multiply. The ring is cleared at
// reset through per-slot valid bits, so no clearing pass is needed.
// Configuration writes take effect at once and should be made between ticks.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_range_average_alarm_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_echo_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_trigger_out,
  output logic                                   out_buzzer_out,
  output logic                                   out_average_valid,
  output logic      [uraa_pkg::DIST_W-1:0]       out_average_distance,
  output logic      [uraa_pkg::STATUS_W-1:0]     out_measure_status,
  input  wire logic                              cfg_we,
  input  wire logic [uraa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [uraa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_FIN
  } tst_t;

  typedef enum logic [2:0] {
    P_TRIGGER,
    P_RISE,
    P_HIGH,
    P_BEEP_ON,
    P_BEEP_OFF,
    P_GAP
  } phase_t;

  tst_t                              tst_r, tst_nxt;
  phase_t                            phase_r, phase_nxt;
  logic [uraa_pkg::TIMER_W-1:0]      timer_r, timer_nxt;
  logic [uraa_pkg::DIST_W-1:0]       held_avg_r, held_avg_nxt;
  logic [uraa_pkg::STATUS_W-1:0]     held_status_r, held_status_nxt;
  logic [uraa_pkg::STATUS_W-1:0]     pend_status_r, pend_status_nxt;
  logic [uraa_pkg::TIMER_W-1:0]      half_r, half_nxt;

  logic [uraa_pkg::TIMER_W-1:0]      echo_timeout_r, echo_timeout_nxt;
  logic [uraa_pkg::TRIG_W-1:0]       trig_len_r, trig_len_nxt;
  logic [uraa_pkg::TIMER_W-1:0]      cycle_gap_r, cycle_gap_nxt;
  logic [uraa_pkg::DIST_W-1:0]       near_r, near_nxt;
  logic [uraa_pkg::DIST_W-1:0]       far_r, far_nxt;
  logic [uraa_pkg::WEIGHT_W-1:0]     weight_r, weight_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_trig_r, out_trig_nxt;
  logic                              out_buzz_r, out_buzz_nxt;
  logic                              out_avg_valid_r, out_avg_valid_nxt;
  logic [uraa_pkg::DIST_W-1:0]       out_avg_r, out_avg_nxt;
  logic [uraa_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;

  logic                              accept;
  logic                              out_free;
  logic [uraa_pkg::TIMER_W:0]        inc;
  logic                              in_range;
  uraa_pkg::uraa_req_t               req;
  uraa_pkg::uraa_rsp_t               rsp;

  uraa_avg u_avg (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .beep_weight (weight_r),
    .rsp         (rsp)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (tst_r == T_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign inc      = {1'b0, timer_r} + 1'b1;
  assign in_range = (rsp.average >= near_r) && (rsp.average <= far_r);

  always_comb begin
    tst_nxt           = tst_r;
    phase_nxt         = phase_r;
    timer_nxt         = timer_r;
    held_avg_nxt      = held_avg_r;
    held_status_nxt   = held_status_r;
    pend_status_nxt   = pend_status_r;
    half_nxt          = half_r;
    echo_timeout_nxt  = echo_timeout_r;
    trig_len_nxt      = trig_len_r;
    cycle_gap_nxt     = cycle_gap_r;
    near_nxt          = near_r;
    far_nxt           = far_r;
    weight_nxt        = weight_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_trig_nxt      = out_trig_r;
    out_buzz_nxt      = out_buzz_r;
    out_avg_valid_nxt = out_avg_valid_r;
    out_avg_nxt       = out_avg_r;
    out_status_nxt    = out_status_r;
    req.start         = 1'b0;
    req.width         = '0;

    // Take configuration writes
    if (cfg_we) begin
      case (cfg_index)
        uraa_pkg::CFG_ECHO_TIMEOUT:   echo_timeout_nxt = cfg_data[uraa_pkg::TIMER_W-1:0];
        uraa_pkg::CFG_TRIGGER_LENGTH: trig_len_nxt     = cfg_data[uraa_pkg::TRIG_W-1:0];
        uraa_pkg::CFG_CYCLE_GAP:      cycle_gap_nxt    = cfg_data[uraa_pkg::TIMER_W-1:0];
        uraa_pkg::CFG_NEAR_LIMIT:     near_nxt         = cfg_data;
        uraa_pkg::CFG_FAR_LIMIT:      far_nxt          = cfg_data;
        uraa_pkg::CFG_BEEP_WEIGHT:    weight_nxt       = cfg_data[uraa_pkg::WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end

    case (tst_r)
      // Advance the phase by one tick
      T_IDLE: begin
        if (accept) begin
          out_valid_nxt     = 1'b1;
          out_trig_nxt      = 1'b0;
          out_buzz_nxt      = 1'b0;
          out_avg_valid_nxt = 1'b0;
          out_avg_nxt       = held_avg_r;
          out_status_nxt    = held_status_r;
          timer_nxt         = inc[uraa_pkg::TIMER_W-1:0];
          case (phase_r)
            P_TRIGGER: begin
              out_trig_nxt = 1'b1;
              if (inc >= (uraa_pkg::TIMER_W + 1)'(trig_len_r)) begin
                phase_nxt = P_RISE;
                timer_nxt = '0;
              end
            end
            P_RISE: begin
              if (in_echo_level) begin
                phase_nxt = P_HIGH;
                timer_nxt = '0;
              end else if (inc >= {1'b0, echo_timeout_r}) begin
                req.start       = 1'b1;
                req.width       = '0;
                pend_status_nxt = uraa_pkg::ST_NO_RISE;
              end
            end
            P_HIGH: begin
              if (!in_echo_level) begin
                req.start       = 1'b1;
                req.width       = inc[uraa_pkg::TIMER_W-1:0];
                pend_status_nxt = uraa_pkg::ST_OK;
              end else if (inc >= {1'b0, echo_timeout_r}) begin
                req.start       = 1'b1;
                req.width       = echo_timeout_r;
                pend_status_nxt = uraa_pkg::ST_TOO_LONG;
              end
            end
            P_BEEP_ON: begin
              out_buzz_nxt = 1'b1;
              if (inc >= {1'b0, half_r}) begin
                phase_nxt = P_BEEP_OFF;
                timer_nxt = '0;
              end
            end
            P_BEEP_OFF: begin
              if (inc >= {1'b0, half_r}) begin
                phase_nxt = (cycle_gap_r == '0) ? P_TRIGGER : P_GAP;
                timer_nxt = '0;
              end
            end
            P_GAP: begin
              if (inc >= {1'b0, cycle_gap_r}) begin
                phase_nxt = P_TRIGGER;
                timer_nxt = '0;
              end
            end
            default: begin
              phase_nxt = P_TRIGGER;
              timer_nxt = '0;
            end
          endcase
          // Hold the beat back until the average is ready
          if (req.start) begin
            out_valid_nxt = out_valid_r && !out_ready;
            out_trig_nxt  = out_trig_r;
            out_buzz_nxt  = out_buzz_r;
            timer_nxt     = '0;
            tst_nxt       = T_BUSY;
          end
        end
      end
      // Wait for the averaging engine
      T_BUSY: begin
        if (rsp.done) begin
          tst_nxt = T_FIN;
        end
      end
      // Publish the average and pick the next phase
      T_FIN: begin
        if (out_free) begin
          held_avg_nxt      = rsp.average;
          held_status_nxt   = pend_status_r;
          out_valid_nxt     = 1'b1;
          out_trig_nxt      = 1'b0;
          out_buzz_nxt      = 1'b0;
          out_avg_valid_nxt = 1'b1;
          out_avg_nxt       = rsp.average;
          out_status_nxt    = pend_status_r;
          timer_nxt         = '0;
          if (in_range) begin
            half_nxt = rsp.half_period;
          end
          if (in_range && (rsp.half_period != '0)) begin
            phase_nxt = P_BEEP_ON;
          end else begin
            phase_nxt = (cycle_gap_r == '0) ? P_TRIGGER : P_GAP;
          end
          tst_nxt = T_IDLE;
        end
      end
      default: begin
        tst_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tst_r          <= T_IDLE;
      phase_r        <= P_TRIGGER;
      timer_r        <= '0;
      held_avg_r     <= '0;
      held_status_r  <= uraa_pkg::ST_OK;
      half_r         <= '0;
      echo_timeout_r <= uraa_pkg::RST_ECHO_TIMEOUT;
      trig_len_r     <= uraa_pkg::RST_TRIGGER_LENGTH;
      cycle_gap_r    <= uraa_pkg::RST_CYCLE_GAP;
      near_r         <= uraa_pkg::RST_NEAR_LIMIT;
      far_r          <= uraa_pkg::RST_FAR_LIMIT;
      weight_r       <= uraa_pkg::RST_BEEP_WEIGHT;
      out_valid_r    <= 1'b0;
    end else begin
      tst_r          <= tst_nxt;
      phase_r        <= phase_nxt;
      timer_r        <= timer_nxt;
      held_avg_r     <= held_avg_nxt;
      held_status_r  <= held_status_nxt;
      half_r         <= half_nxt;
      echo_timeout_r <= echo_timeout_nxt;
      trig_len_r     <= trig_len_nxt;
      cycle_gap_r    <= cycle_gap_nxt;
      near_r         <= near_nxt;
      far_r          <= far_nxt;
      weight_r       <= weight_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    pend_status_r   <= pend_status_nxt;
    out_trig_r      <= out_trig_nxt;
    out_buzz_r      <= out_buzz_nxt;
    out_avg_valid_r <= out_avg_valid_nxt;
    out_avg_r       <= out_avg_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_trigger_out      = out_trig_r;
  assign out_buzzer_out       = out_buzz_r;
  assign out_average_valid    = out_avg_valid_r;
  assign out_average_distance = out_avg_r;
  assign out_measure_status   = out_status_r;

endmodule
`default_nettype wire

// ----- sv/uraa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module uraa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/uraa_avg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module uraa_avg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire uraa_pkg::uraa_req_t            req,
  input  wire logic [uraa_pkg::WEIGHT_W-1:0]  beep_weight,
  output uraa_pkg::uraa_rsp_t                 rsp
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_DIST,
    E_ACC,
    E_DIV,
    E_MUL,
    E_SAT
  } est_t;

  est_t                              st_r, st_nxt;
  logic [uraa_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [uraa_pkg::RING_DEPTH-1:0]   vld_r, vld_nxt;
  logic [uraa_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [uraa_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [uraa_pkg::TIMER_W-1:0]      width_r, width_nxt;
  logic [uraa_pkg::DIST_W-1:0]       dist_r, dist_nxt;
  logic [uraa_pkg::DIST_W-1:0]       old_r, old_nxt;
  logic [uraa_pkg::WMUL_W-1:0]       wmul_r, wmul_nxt;
  logic [uraa_pkg::SUM_W-1:0]        quo_r, quo_nxt;
  logic [uraa_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [uraa_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [uraa_pkg::DIST_W-1:0]       avg_r, avg_nxt;
  logic [uraa_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [uraa_pkg::TIMER_W-1:0]      half_r, half_nxt;
  logic                              done_r, done_nxt;

  logic                              ram_we;
  logic [uraa_pkg::DIST_W-1:0]       ram_rdata;
  logic [uraa_pkg::DIST_PROD_W-1:0]  dist_prod;
  logic [uraa_pkg::DIST_W-1:0]       dist_sat;
  logic [uraa_pkg::CNT_W:0]          trial;
  logic [uraa_pkg::CNT_W:0]          diff;
  logic                              ge;
  logic [uraa_pkg::DIST_W-1:0]       avg_val;

  // Ring storage: one read of the slot about to be replaced, one write back
  uraa_ram #(
    .WIDTH (uraa_pkg::DIST_W),
    .DEPTH (uraa_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (dist_r),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Convert echo width to distance, saturate at the field width
  assign dist_prod = uraa_pkg::DIST_PROD_W'(width_r)
                   * uraa_pkg::DIST_PROD_W'(uraa_pkg::DIST_SCALE);
  assign dist_sat  = (|dist_prod[uraa_pkg::DIST_PROD_W-1:uraa_pkg::DIST_SHIFT+uraa_pkg::DIST_W])
                   ? '1
                   : dist_prod[uraa_pkg::DIST_SHIFT+uraa_pkg::DIST_W-1:uraa_pkg::DIST_SHIFT];

  // One restoring division step per cycle
  assign trial = {rem_r, quo_r[uraa_pkg::SUM_W-1]};
  assign ge    = (trial >= {1'b0, cnt_r});
  assign diff  = trial - {1'b0, cnt_r};

  // Empty ring averages to zero
  assign avg_val = (cnt_r == '0) ? '0 : quo_r[uraa_pkg::DIST_W-1:0];

  always_comb begin
    st_nxt    = st_r;
    pos_nxt   = pos_r;
    vld_nxt   = vld_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    dist_nxt  = dist_r;
    old_nxt   = old_r;
    wmul_nxt  = wmul_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    avg_nxt   = avg_r;
    prod_nxt  = prod_r;
    half_nxt  = half_r;
    done_nxt  = 1'b0;
    ram_we    = 1'b0;
    case (st_r)
      // Latch the width; the slot read is issued at the same edge
      E_IDLE: begin
        if (req.start) begin
          width_nxt = req.width;
          st_nxt    = E_DIST;
        end
      end
      // Take the old slot value; never-written slots read as zero
      E_DIST: begin
        dist_nxt = dist_sat;
        old_nxt  = vld_r[pos_r] ? ram_rdata : '0;
        wmul_nxt = uraa_pkg::WMUL_W'(beep_weight) * uraa_pkg::WMUL_W'(uraa_pkg::BEEP_SCALE);
        st_nxt   = E_ACC;
      end
      // Write back, update running sum and nonzero count, seed divider
      E_ACC: begin
        ram_we         = 1'b1;
        vld_nxt[pos_r] = 1'b1;
        pos_nxt        = (pos_r == uraa_pkg::POS_W'(uraa_pkg::RING_DEPTH - 1))
                       ? '0 : pos_r + 1'b1;
        sum_nxt        = sum_r - uraa_pkg::SUM_W'(old_r) + uraa_pkg::SUM_W'(dist_r);
        cnt_nxt        = cnt_r - uraa_pkg::CNT_W'(old_r != '0)
                       + uraa_pkg::CNT_W'(dist_r != '0);
        quo_nxt        = sum_nxt;
        rem_nxt        = '0;
        step_nxt       = '0;
        st_nxt         = E_DIV;
      end
      // Shift one quotient bit in per cycle
      E_DIV: begin
        rem_nxt  = ge ? diff[uraa_pkg::CNT_W-1:0] : trial[uraa_pkg::CNT_W-1:0];
        quo_nxt  = {quo_r[uraa_pkg::SUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == uraa_pkg::STEP_W'(uraa_pkg::SUM_W - 1)) begin
          st_nxt = E_MUL;
        end
      end
      // Scale the average for the buzzer half period
      E_MUL: begin
        avg_nxt  = avg_val;
        prod_nxt = uraa_pkg::PROD_W'(avg_val) * uraa_pkg::PROD_W'(wmul_r);
        st_nxt   = E_SAT;
      end
      // Saturate the half period and report
      E_SAT: begin
        half_nxt = (|prod_r[uraa_pkg::PROD_W-1:uraa_pkg::BEEP_SHIFT+uraa_pkg::TIMER_W])
                 ? '1
                 : prod_r[uraa_pkg::BEEP_SHIFT+uraa_pkg::TIMER_W-1:uraa_pkg::BEEP_SHIFT];
        done_nxt = 1'b1;
        st_nxt   = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      pos_r  <= '0;
      vld_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      vld_r  <= vld_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    width_r <= width_nxt;
    dist_r  <= dist_nxt;
    old_r   <= old_nxt;
    wmul_r  <= wmul_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    avg_r   <= avg_nxt;
    prod_r  <= prod_nxt;
    half_r  <= half_nxt;
  end

  assign rsp.done        = done_r;
  assign rsp.average     = avg_r;
  assign rsp.half_period = half_r;

endmodule
`default_nettype wire

// ----- sv/uraa_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module uraa_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_trigger_out,
  input wire logic                              out_buzzer_out,
  input wire logic                              out_average_valid,
  input wire logic [uraa_pkg::DIST_W-1:0]       out_average_distance,
  input wire logic [uraa_pkg::STATUS_W-1:0]     out_measure_status
);

  // A stalled result beat keeps its payload
  `URAA_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_average_distance) && $stable(out_measure_status) && $stable(out_average_valid)), "result beat changed while stalled")

  // Trigger and buzzer phases never overlap
  `URAA_ASSERT_NEVER(a_trig_buzz, out_valid && out_trigger_out && out_buzzer_out, "trigger and buzzer driven together")

  // A new average comes on a tick with both pins low
  `URAA_ASSERT_NEVER(a_avg_quiet, out_valid && out_average_valid && (out_trigger_out || out_buzzer_out), "pin driven on an average beat")

  // Status is one of the defined codes
  `URAA_ASSERT_NEVER(a_status_code, out_valid && out_measure_status != uraa_pkg::ST_OK && out_measure_status != uraa_pkg::ST_NO_RISE && out_measure_status != uraa_pkg::ST_TOO_LONG, "undefined status code")

endmodule

bind ultrasonic_range_average_alarm_core uraa_chk u_uraa_chk (.*);
`default_nettype wire

// ----- bench/uraa_tick_checker.sv -----
`timescale 1ns / 1ps
module uraa_tick_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_echo_level,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_trigger_out,
  input  logic                            out_buzzer_out,
  input  logic                            out_average_valid,
  input  logic [uraa_pkg::DIST_W-1:0]     out_average_distance,
  input  logic [uraa_pkg::STATUS_W-1:0]   out_measure_status,
  input  logic                            cfg_we,
  input  logic [uraa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uraa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              ticks_checked,
  output int                              averages_seen,
  output int                              no_rise_seen,
  output int                              too_long_seen,
  output int                              buzz_ticks
);
  import uraa_pkg::*;

  typedef enum logic [2:0] {
    SEQ_TRIGGER,
    SEQ_WAIT_RISE,
    SEQ_ECHO_HIGH,
    SEQ_BUZZ_ON,
    SEQ_BUZZ_OFF,
    SEQ_GAP
  } seq_phase_t;

  typedef struct packed {
    logic                trig;
    logic                buzz;
    logic                avg_valid;
    logic [DIST_W-1:0]   avg;
    logic [STATUS_W-1:0] status;
  } tick_beat_t;

  // Shadow of the sequencer and its registers
  seq_phase_t          seq_phase;
  logic [TIMER_W-1:0]  tick_count;
  logic [DIST_W-1:0]   dist_slot [RING_DEPTH];
  int                  slot_ptr;
  logic [DIST_W-1:0]   avg_hold;
  logic [TIMER_W-1:0]  half_period;
  logic [STATUS_W-1:0] status_hold;

  logic [TIMER_W-1:0]  timeout_cfg;
  logic [TRIG_W-1:0]   trig_len_cfg;
  logic [TIMER_W-1:0]  gap_cfg;
  logic [DIST_W-1:0]   near_cfg;
  logic [DIST_W-1:0]   far_cfg;
  logic [WEIGHT_W-1:0] weight_cfg;

  tick_beat_t expected_ticks[$];

  int fails = 0;
  int checked = 0;
  int n_avg = 0;
  int n_no_rise = 0;
  int n_too_long = 0;
  int n_buzz = 0;

  // Store one distance, refresh the average and pick buzzer or gap
  function automatic void close_measurement(input logic [TIMER_W-1:0] width,
                                            input logic [STATUS_W-1:0] st);
    longint dist_val;
    longint total;
    longint beep;
    int     nonzero;
    dist_val = (longint'(width) * DIST_SCALE) >> DIST_SHIFT;
    if (dist_val > 64'hFF_FFFF) dist_val = 64'hFF_FFFF;
    dist_slot[slot_ptr] = dist_val[DIST_W-1:0];
    slot_ptr = (slot_ptr + 1) % RING_DEPTH;
    total = 0;
    nonzero = 0;
    foreach (dist_slot[i]) begin
      total += dist_slot[i];
      if (dist_slot[i] != '0) nonzero++;
    end
    avg_hold = (nonzero == 0) ? '0 : DIST_W'(total / nonzero);
    status_hold = st;
    if (avg_hold >= near_cfg && avg_hold <= far_cfg) begin
      beep = (longint'(avg_hold) * longint'(weight_cfg) * BEEP_SCALE) >> BEEP_SHIFT;
      if (beep > 64'h3F_FFFF) beep = 64'h3F_FFFF;
      half_period = beep[TIMER_W-1:0];
      if (half_period != '0) begin
        seq_phase = SEQ_BUZZ_ON;
        return;
      end
    end
    seq_phase = (gap_cfg == '0) ? SEQ_TRIGGER : SEQ_GAP;
  endfunction

  // Advance the shadow by one tick and return the beat it must produce
  function automatic tick_beat_t predict_tick(input logic echo);
    tick_beat_t  r;
    logic [TIMER_W:0] t;
    r = '0;
    t = tick_count + 1;
    case (seq_phase)
      SEQ_TRIGGER: begin
        r.trig = 1'b1;
        if (t >= trig_len_cfg) begin
          seq_phase = SEQ_WAIT_RISE;
          t = '0;
        end
      end
      SEQ_WAIT_RISE: begin
        if (echo) begin
          seq_phase = SEQ_ECHO_HIGH;
          t = '0;
        end else if (t >= timeout_cfg) begin
          r.avg_valid = 1'b1;
          close_measurement('0, ST_NO_RISE);
          t = '0;
        end
      end
      SEQ_ECHO_HIGH: begin
        if (!echo) begin
          r.avg_valid = 1'b1;
          close_measurement(t[TIMER_W-1:0], ST_OK);
          t = '0;
        end else if (t >= timeout_cfg) begin
          r.avg_valid = 1'b1;
          close_measurement(timeout_cfg, ST_TOO_LONG);
          t = '0;
        end
      end
      SEQ_BUZZ_ON: begin
        r.buzz = 1'b1;
        if (t >= half_period) begin
          seq_phase = SEQ_BUZZ_OFF;
          t = '0;
        end
      end
      SEQ_BUZZ_OFF: begin
        if (t >= half_period) begin
          seq_phase = (gap_cfg == '0) ? SEQ_TRIGGER : SEQ_GAP;
          t = '0;
        end
      end
      SEQ_GAP: begin
        if (t >= gap_cfg) begin
          seq_phase = SEQ_TRIGGER;
          t = '0;
        end
      end
      default: begin
        seq_phase = SEQ_TRIGGER;
        t = '0;
      end
    endcase
    tick_count = t[TIMER_W-1:0];
    r.avg = avg_hold;
    r.status = status_hold;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    tick_beat_t want;
    tick_beat_t got;
    if (!rst_n) begin
      seq_phase = SEQ_TRIGGER;
      tick_count = '0;
      foreach (dist_slot[i]) dist_slot[i] = '0;
      slot_ptr = 0;
      avg_hold = '0;
      half_period = '0;
      status_hold = ST_OK;
      timeout_cfg = RST_ECHO_TIMEOUT;
      trig_len_cfg = RST_TRIGGER_LENGTH;
      gap_cfg = RST_CYCLE_GAP;
      near_cfg = RST_NEAR_LIMIT;
      far_cfg = RST_FAR_LIMIT;
      weight_cfg = RST_BEEP_WEIGHT;
      expected_ticks.delete();
    end else begin
      // Register writes land before any tick of the same edge
      if (cfg_we) begin
        case (cfg_index)
          CFG_ECHO_TIMEOUT:   timeout_cfg = cfg_data[TIMER_W-1:0];
          CFG_TRIGGER_LENGTH: trig_len_cfg = cfg_data[TRIG_W-1:0];
          CFG_CYCLE_GAP:      gap_cfg = cfg_data[TIMER_W-1:0];
          CFG_NEAR_LIMIT:     near_cfg = cfg_data[DIST_W-1:0];
          CFG_FAR_LIMIT:      far_cfg = cfg_data[DIST_W-1:0];
          CFG_BEEP_WEIGHT:    weight_cfg = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_ticks.push_back(predict_tick(in_echo_level));
      // Match each result beat against the oldest outstanding tick
      if (out_valid && out_ready) begin
        got = '{out_trigger_out, out_buzzer_out, out_average_valid,
                out_average_distance, out_measure_status};
        if (expected_ticks.size() == 0) begin
          $error("result beat arrived with no tick outstanding");
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          compare_field("trigger_out", want.trig, got.trig);
          compare_field("buzzer_out", want.buzz, got.buzz);
          compare_field("average_valid", want.avg_valid, got.avg_valid);
          compare_field("average_distance", want.avg, got.avg);
          compare_field("measure_status", want.status, got.status);
          checked++;
          if (want.buzz) n_buzz++;
          if (want.avg_valid) begin
            n_avg++;
            if (want.status == ST_NO_RISE) n_no_rise++;
            if (want.status == ST_TOO_LONG) n_too_long++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending       <= expected_ticks.size();
    ticks_checked <= checked;
    averages_seen <= n_avg;
    no_rise_seen  <= n_no_rise;
    too_long_seen <= n_too_long;
    buzz_ticks    <= n_buzz;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import uraa_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_PHASES  = 4;
  localparam int QUIET_TICKS   = 20;
  localparam int ALARM_PHASES  = 1;
  localparam int ALARM_TICKS   = 340;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_echo_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_trigger_out;
  logic                  out_buzzer_out;
  logic                  out_average_valid;
  logic [DIST_W-1:0]     out_average_distance;
  logic [STATUS_W-1:0]   out_measure_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ECHO_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int ticks_checked;
  int averages_seen;
  int no_rise_seen;
  int too_long_seen;
  int buzz_ticks;

  int idle_max = 0;
  int settings_used = 0;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ultrasonic_range_average_alarm_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_echo_level        (in_echo_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_trigger_out      (out_trigger_out),
    .out_buzzer_out       (out_buzzer_out),
    .out_average_valid    (out_average_valid),
    .out_average_distance (out_average_distance),
    .out_measure_status   (out_measure_status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  uraa_tick_checker tick_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_echo_level        (in_echo_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_trigger_out      (out_trigger_out),
    .out_buzzer_out       (out_buzzer_out),
    .out_average_valid    (out_average_valid),
    .out_average_distance (out_average_distance),
    .out_measure_status   (out_measure_status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending              (pending),
    .ticks_checked        (ticks_checked),
    .averages_seen        (averages_seen),
    .no_rise_seen         (no_rise_seen),
    .too_long_seen        (too_long_seen),
    .buzz_ticks           (buzz_ticks)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off to back the block up
  initial begin : result_sink
    int taken;
    int gap;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, idle_max);
      if (taken == HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Offer one tick and hold it until the block takes the beat
  task automatic send_tick(input logic level);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo_level <= level;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  // Drop valid and let every outstanding tick come back before a register write
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [TIMER_W-1:0] tmo, input logic [TRIG_W-1:0] trig,
                              input logic [TIMER_W-1:0] gap, input logic [DIST_W-1:0] near_lim,
                              input logic [DIST_W-1:0] far_lim,
                              input logic [WEIGHT_W-1:0] weight);
    put_reg(CFG_ECHO_TIMEOUT, CFG_DATA_W'(tmo));
    put_reg(CFG_TRIGGER_LENGTH, CFG_DATA_W'(trig));
    put_reg(CFG_CYCLE_GAP, CFG_DATA_W'(gap));
    put_reg(CFG_NEAR_LIMIT, CFG_DATA_W'(near_lim));
    put_reg(CFG_FAR_LIMIT, CFG_DATA_W'(far_lim));
    put_reg(CFG_BEEP_WEIGHT, CFG_DATA_W'(weight));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Alternate echo levels in runs of random length, with single-tick glitches
  task automatic echo_runs(input int count, input int max_run);
    int   done;
    int   len;
    logic lvl;
    done = 0;
    lvl = 1'b0;
    while (done < count) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, max_run);
      if (len > count - done) len = count - done;
      send_run(lvl, len);
      done += len;
      lvl = ~lvl;
    end
  endtask

  // Settings under which the buzzer can never sound
  task automatic quiet_phase();
    logic [TIMER_W-1:0]  tmo;
    logic [TRIG_W-1:0]   trig;
    logic [TIMER_W-1:0]  gap;
    logic [DIST_W-1:0]   near_lim;
    logic [DIST_W-1:0]   far_lim;
    logic [WEIGHT_W-1:0] weight;
    int                  max_run;
    case ($urandom_range(0, 7))
      0:       tmo = '0;
      1:       tmo = 22'd1;
      2:       tmo = 22'h3F_FFFF;
      default: tmo = TIMER_W'($urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       trig = '0;
      1:       trig = 8'hFF;
      2:       trig = 8'd1;
      default: trig = TRIG_W'($urandom_range(2, 8));
    endcase
    gap = ($urandom_range(0, 3) == 0) ? '0 : TIMER_W'($urandom_range(1, 6));
    case ($urandom_range(0, 2))
      0: begin
        near_lim = '0;
        far_lim = 24'hFF_FFFF;
        weight = '0;
      end
      1: begin
        near_lim = 24'hFF_FFFF;
        far_lim = '0;
        weight = WEIGHT_W'($urandom_range(0, 15));
      end
      default: begin
        // averages stay far below this window
        near_lim = DIST_W'($urandom_range(24'hFF_FFFF, 4096));
        far_lim = 24'hFF_FFFF;
        weight = WEIGHT_W'($urandom_range(1, 15));
      end
    endcase
    case ($urandom_range(0, 2))
      0:       idle_max = 0;
      1:       idle_max = 5;
      default: idle_max = 18;
    endcase
    max_run = (tmo > 16) ? 20 : int'(tmo) + 4;
    apply_config(tmo, trig, gap, near_lim, far_lim, weight);
    echo_runs(QUIET_TICKS, max_run);
    settle();
  endtask

  // Short echoes and a narrow window so averages land in range and beep
  task automatic alarm_phase();
    logic [DIST_W-1:0] near_lim;
    near_lim = DIST_W'($urandom_range(0, 12));
    idle_max = $urandom_range(0, 1);
    apply_config(TIMER_W'($urandom_range(3, 8)), TRIG_W'($urandom_range(1, 4)),
                 TIMER_W'($urandom_range(0, 3)), near_lim,
                 near_lim + DIST_W'($urandom_range(4, 16)),
                 WEIGHT_W'($urandom_range(1, 2)));
    echo_runs(ALARM_TICKS, 4);
    settle();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    idle_max = 3;

    // Reset settings: full trigger, a short echo, then into the long gap
    send_run(1'b0, 12);
    send_run(1'b1, 3);
    send_tick(1'b0);
    send_run(1'b0, 2);
    settle();

    // Stretch the gap to its maximum while inside it
    apply_config('0, '0, 22'h3F_FFFF, 24'hFF_FFFF, '0, 4'hF);
    send_run(1'b0, 2);
    settle();

    // Zero timeout, zero trigger length, zero gap, alarm window wide open at zero weight
    apply_config('0, '0, '0, '0, 24'hFF_FFFF, '0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_run(1'b1, 4);
    send_tick(1'b0);
    settle();

    repeat (QUIET_PHASES) quiet_phase();
    repeat (ALARM_PHASES) alarm_phase();

    $display("Checked %0d ticks under %0d register settings: %0d averages, %0d without echo, %0d with over-long echo",
             ticks_checked, settings_used, averages_seen, no_rise_seen, too_long_seen);
    $display("Buzzer drove %0d ticks; result side held off once for %0d cycles",
             buzz_ticks, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/uraa_pkg.sv
sv/uraa_ram.sv
sv/uraa_avg.sv
sv/ultrasonic_range_average_alarm_core.sv
sv/uraa_chk.sv
bench/uraa_tick_checker.sv
bench/tb.sv
